@@ rtl/qn_pkg.sv @@
// Shared constants and types for the quaternion normaliser
`default_nettype none
package qn_pkg;
  localparam int COMP_WIDTH   = 32;
  localparam int IN_FRAC_BITS = 16;
  localparam int OUT_WIDTH    = 32;
  localparam int OUT_FRAC     = 30;
  localparam int THR_WIDTH    = 32;
  localparam int THR_FRAC     = 32;
  localparam int NUM_LANES    = 4;

  localparam int MAG_WIDTH = COMP_WIDTH;
  localparam int SQ_WIDTH  = 2 * COMP_WIDTH;
  localparam int SW        = 2 * COMP_WIDTH + 1;
  localparam int QB        = 2 * OUT_FRAC + 3;
  localparam int RB        = OUT_FRAC + 2;
  localparam int RAD_WIDTH = 2 * RB;
  localparam int REM_WIDTH = RB + 4;
  localparam int LANE_LAT  = QB + RB;

  localparam int SUM_SHIFT = (THR_FRAC > 2 * IN_FRAC_BITS) ? THR_FRAC - 2 * IN_FRAC_BITS : 0;
  localparam int THR_SHIFT = (2 * IN_FRAC_BITS > THR_FRAC) ? 2 * IN_FRAC_BITS - THR_FRAC : 0;
  localparam int CMP_WIDTH = SW + THR_WIDTH + SUM_SHIFT + THR_SHIFT;

  localparam logic [OUT_WIDTH-1:0] ONE_Q = OUT_WIDTH'(1) << OUT_FRAC;

  typedef struct packed {
    logic                 valid;
    logic                 deg;
    logic [NUM_LANES-1:0] neg;
  } ctl_t;
endpackage
`default_nettype wire

@@ rtl/qn_front.sv @@
// Front end: magnitudes, squares, sum of squares and degenerate test
`default_nettype none
module qn_front (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        en,
  input  wire logic                                        in_valid,
  input  wire logic [qn_pkg::NUM_LANES*qn_pkg::COMP_WIDTH-1:0] in_data,
  input  wire logic [qn_pkg::THR_WIDTH-1:0]                thr,
  output logic [qn_pkg::NUM_LANES-1:0][qn_pkg::SQ_WIDTH-1:0] c2,
  output logic [qn_pkg::SW-1:0]                            sum_sq,
  output qn_pkg::ctl_t                                     ctl
);
  import qn_pkg::*;

  logic [NUM_LANES-1:0][MAG_WIDTH-1:0] mag;
  logic [NUM_LANES-1:0]                neg_a, neg_b;
  logic                                valid_a, valid_b;
  logic [NUM_LANES-1:0][SQ_WIDTH-1:0]  sq;
  logic [SW-1:0]                       sum_next;
  logic [CMP_WIDTH-1:0]                sum_cmp, thr_cmp;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      ctl.valid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        neg_a[i] <= in_data[i*COMP_WIDTH + COMP_WIDTH-1];
        mag[i]   <= in_data[i*COMP_WIDTH + COMP_WIDTH-1] ?
                    (~in_data[i*COMP_WIDTH +: COMP_WIDTH]) + MAG_WIDTH'(1) :
                    in_data[i*COMP_WIDTH +: COMP_WIDTH];
        sq[i]    <= SQ_WIDTH'(mag[i]) * SQ_WIDTH'(mag[i]);
      end
      neg_b   <= neg_a;
      c2      <= sq;
      sum_sq  <= sum_next;
      ctl.neg <= neg_b;
      ctl.deg <= (sum_cmp <= thr_cmp);
    end
  end

  always_comb begin
    sum_next = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]) + SW'(sq[3]);
    sum_cmp  = CMP_WIDTH'(sum_next) << SUM_SHIFT;
    thr_cmp  = CMP_WIDTH'(thr) << THR_SHIFT;
  end
endmodule
`default_nettype wire

@@ rtl/qn_lane.sv @@
// One lane: pipelined restoring divider followed by a pipelined square root
`default_nettype none
module qn_lane (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic [qn_pkg::SQ_WIDTH-1:0]            c2,
  input  wire logic [qn_pkg::QB-1:0][qn_pkg::SW-1:0]  s_pl,
  output logic [qn_pkg::RB-1:0]                       root
);
  import qn_pkg::*;

  logic [QB-1:0][SW-1:0]        drem;
  logic [QB-1:0][QB-1:0]        quo;
  logic [RB-1:0][REM_WIDTH-1:0] srem;
  logic [RB-1:0][RAD_WIDTH-1:0] rad;
  logic [RB-1:0][RB-1:0]        sroot;

  // Divider: one quotient bit of c^2 * 2^62 / S a stage
  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [SW:0] r2, diff;
    logic        ge;
    if (i == 0) begin : g_first
      assign r2 = (SW+1)'(c2);
    end else begin : g_rest
      assign r2 = {drem[i-1], 1'b0};
    end
    assign diff = r2 - {1'b0, s_pl[i]};
    assign ge   = (r2 >= {1'b0, s_pl[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        drem[i] <= ge ? diff[SW-1:0] : r2[SW-1:0];
        if (i == 0) begin
          quo[i] <= QB'(ge);
        end else begin
          quo[i] <= {quo[(i == 0) ? 0 : i-1][QB-2:0], ge};
        end
      end
    end
  end

  // Square root: one result bit a stage, two radicand bits consumed
  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    logic [REM_WIDTH-1:0] rsh, trial;
    logic [RAD_WIDTH-1:0] rin;
    logic [RB-1:0]        rprev;
    logic                 ge;
    if (j == 0) begin : g_first
      assign rin   = RAD_WIDTH'(quo[QB-1]);
      assign rsh   = REM_WIDTH'(rin[RAD_WIDTH-1 -: 2]);
      assign rprev = '0;
    end else begin : g_rest
      assign rin   = rad[j-1];
      assign rsh   = {srem[j-1][REM_WIDTH-3:0], rin[RAD_WIDTH-1 -: 2]};
      assign rprev = sroot[j-1];
    end
    assign trial = REM_WIDTH'({rprev, 2'b01});
    assign ge    = (rsh >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        srem[j]  <= ge ? rsh - trial : rsh;
        rad[j]   <= {rin[RAD_WIDTH-3:0], 2'b00};
        sroot[j] <= {rprev[RB-2:0], ge};
      end
    end
  end

  assign root = sroot[RB-1];
endmodule
`default_nettype wire

@@ rtl/quaternion_normalizer.sv @@
// Top level of the quaternion normaliser: front end, four lanes, output merge
//
// Scales a quaternion of four signed Q16.16 components to unit length in
// signed Q2.30, rounded to nearest (ties away from zero).
// Input request on s_*: s_tdata holds w, x, y, z from the lowest bit up.
// Result on m_*: m_tdata holds w, x, y, z in Q2.30, m_tuser the degenerate
// flag; a sum of squares at or below thr gives (1,0,0,0) with the flag.
// cfg_wr_en / cfg_wr_data write thr (units of 2^-32); write it only
// while the block is empty.
// Pipeline from acceptance to m_tvalid: three front stages (magnitude,
// square, sum and threshold test), 63 divider stages, 32 square root stages
// and the output register. Throughput is one request a cycle while the
// receiver does not stall; each lane divides and takes the root in its own
// pipeline, so nothing is shared between requests.
// Reset clears every valid bit and sets min_len_sq to zero.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline holds and s_tready falls; it rises in the cycle the result is taken.
`default_nettype none
module quaternion_normalizer (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,   // in_w, in_x, in_y, in_z
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,   // out_w, out_x, out_y, out_z
  output logic              m_tuser,   // degenerate
  input  wire logic         cfg_wr_en,
  input  wire logic [31:0]  cfg_wr_data
);
  import qn_pkg::*;

  logic                                min_len_sq;
  logic [THR_WIDTH-1:0]                thr;
  logic                                en;
  logic [NUM_LANES-1:0][SQ_WIDTH-1:0]  c2;
  logic [SW-1:0]                       sum_sq;
  logic [QB-1:1][SW-1:0]               s_dly;
  logic [QB-1:0][SW-1:0]               s_pl;
  ctl_t                                ctl_pl [LANE_LAT+1];
  logic [NUM_LANES-1:0][RB-1:0]        root;
  logic [NUM_LANES-1:0][OUT_WIDTH-1:0] res_next;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end
  assign min_len_sq = |thr;

  // Advance everything unless a result is waiting on a stalled receiver
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  qn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .in_data  (s_tdata),
    .thr      (thr),
    .c2       (c2),
    .sum_sq   (sum_sq),
    .ctl      (ctl_pl[0])
  );

  // Carry S beside the divider stages; all lanes share it
  always_ff @(posedge clk) begin
    if (en) begin
      s_dly[1] <= sum_sq;
      for (int i = 2; i < QB; i++) begin
        s_dly[i] <= s_dly[i-1];
      end
    end
  end
  assign s_pl = {s_dly, sum_sq};

  // Control pipeline: valid, degenerate flag and signs track the lanes
  for (genvar k = 1; k <= LANE_LAT; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_pl[k].valid <= 1'b0;
      end else if (en) begin
        ctl_pl[k].valid <= ctl_pl[k-1].valid;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ctl_pl[k].deg <= ctl_pl[k-1].deg;
        ctl_pl[k].neg <= ctl_pl[k-1].neg;
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    qn_lane u_lane (
      .clk  (clk),
      .en   (en),
      .c2   (c2[l]),
      .s_pl (s_pl),
      .root (root[l])
    );
  end

  // Merge: round the root to the Q2.30 magnitude, apply sign or identity
  always_comb begin
    logic [RB:0]          rnd;
    logic [OUT_WIDTH-1:0] mag;
    for (int l = 0; l < NUM_LANES; l++) begin
      rnd = {1'b0, root[l]} + (RB+1)'(1);
      mag = OUT_WIDTH'(rnd[RB:1]);
      if (ctl_pl[LANE_LAT].deg) begin
        res_next[l] = (l == 0) ? ONE_Q : '0;
      end else begin
        res_next[l] = ctl_pl[LANE_LAT].neg[l] ? (~mag) + OUT_WIDTH'(1) : mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ctl_pl[LANE_LAT].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= res_next;
      m_tuser <= ctl_pl[LANE_LAT].deg;
    end
  end

  // Degenerate results carry exactly the identity
  a_deg_identity: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == {96'd0, ONE_Q})
    else $error("degenerate result is not the identity");

  // The w component stays within plus or minus one
  a_w_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:0]) <= $signed(ONE_Q)) &&
                 ($signed(m_tdata[31:0]) >= -$signed(ONE_Q)))
    else $error("out_w outside the unit range");

  // Input back-pressure only comes from a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without an output stall");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // The threshold register and its flag follow the configuration write
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> thr == $past(cfg_wr_data) && min_len_sq == |$past(cfg_wr_data))
    else $error("threshold register not written");
endmodule
`default_nettype wire

@@ bench/tb_quaternion_normalizer.sv @@
// Testbench for the quaternion normaliser: streamed requests checked against a bit-exact predictor
`default_nettype none
module tb_quaternion_normalizer;
  timeunit 1ns;
  timeprecision 1ps;
  import qn_pkg::*;

  localparam int LATENCY   = 99;
  localparam int CYCLE_CAP = 2000000;

  typedef struct packed {
    logic signed [31:0] z, y, x, w;
  } quat_t;

  typedef struct {
    logic [31:0] w, x, y, z;
    logic        deg;
  } unit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic m_tuser;
  logic cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  quaternion_normalizer u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Threshold as currently programmed, mirrored for the predictor
  logic [31:0] thresh_q = '0;
  quat_t pending_q[$];
  unit_t expected_q[$];
  int mismatches = 0;
  longint cycles = 0;
  bit hold_rx = 1'b0;  // long receiver hold-off, set by the stimulus process
  bit rx_random = 1'b1;
  bit s_taken = 1'b0;  // request accepted at the last rising edge

  // Exact normalisation: magnitude m is the largest in [0, 2^30] with
  // (2m-1)^2 * S <= c^2 * 2^62. Products stay below 2^224, so 256 bits suffice.
  function automatic logic [31:0] lane_scale(logic [32:0] mag, logic [255:0] sum_sq);
    logic [255:0] rhs, lhs, t;
    logic [31:0] lo, hi, mid;
    rhs = (256'(mag) * 256'(mag)) << 62;
    lo = 0;
    hi = 32'h4000_0000;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = 256'(2 * mid - 1);
      lhs = t * t * sum_sq;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic unit_t normalise(quat_t q);
    unit_t r;
    logic signed [31:0] c[4];
    logic [32:0] mag[4];
    logic [255:0] s;
    logic [31:0] m;
    c = '{q.w, q.x, q.y, q.z};
    s = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = c[i][31] ? 33'(-$signed({c[i][31], c[i]})) : 33'(c[i]);
      s += 256'(mag[i]) * 256'(mag[i]);
    end
    // S already carries 32 fractional bits, the same scale as the threshold
    if (s <= 256'(thresh_q)) begin
      r = '{w: ONE_Q, x: 0, y: 0, z: 0, deg: 1'b1};
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      m = lane_scale(mag[i], s);
      if (c[i][31]) m = -m;
      case (i)
        0: r.w = m;
        1: r.x = m;
        2: r.y = m;
        default: r.z = m;
      endcase
    end
    r.deg = 1'b0;
    return r;
  endfunction

  int tx_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_taken) begin
      // hold the request until taken
    end else if (tx_gap > 0) begin
      tx_gap <= tx_gap - 1;
      s_tvalid <= 1'b0;
    end else if (pending_q.size() > 0) begin
      quat_t q;
      q = pending_q.pop_front();
      expected_q.push_back(normalise(q));
      s_tdata <= q;
      s_tvalid <= 1'b1;
      tx_gap <= ($urandom_range(0, 3) == 0) ?
                (($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2)) : 0;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Receiver: random stalls, mostly short, sometimes long; held off by hold_rx, always ready when rx_random is clear
  int rx_gap = 0;
  always @(negedge clk) begin
    if (rst || hold_rx) begin
      m_tready <= 1'b0;
    end else if (!rx_random) begin
      m_tready <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 4) == 0)
        rx_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    s_taken <= !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h deg %b", m_tdata, m_tuser);
      end else begin
        unit_t e;
        e = expected_q.pop_front();
        if (m_tdata !== {e.z, e.y, e.x, e.w} || m_tuser !== e.deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp w %h x %h y %h z %h deg %b, got %h deg %b",
                     e.w, e.x, e.y, e.z, e.deg, m_tdata, m_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("tb_quaternion_normalizer: errors");
      $finish;
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 200)) - 100);
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      3: return ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7fff_ffff;
      4: return 32'($urandom) >>> $urandom_range(0, 31);
      default: return 32'h0;
    endcase
  endfunction

  task automatic push(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    quat_t q;
    q.w = w; q.x = x; q.y = y; q.z = z;
    pending_q.push_back(q);
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) push(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  // Drain everything, let the pipeline settle, then reprogram the threshold
  task automatic set_threshold(logic [31:0] v);
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    @(negedge clk);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    thresh_q = v;
  endtask

  initial begin
    logic [31:0] thr[5];
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero quaternion, extremes, single axes, ties
    set_threshold(32'h0);
    push(0, 0, 0, 0);
    push(32'h0001_0000, 0, 0, 0);
    push(0, 32'hffff_0000, 0, 0);
    push(0, 0, 32'h8000_0000, 0);
    push(0, 0, 0, 32'h7fff_ffff);
    push(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push(1, 0, 0, 0);
    push(32'hffff_ffff, 1, 32'hffff_ffff, 1);
    push(1, 1, 1, 1);
    push(3, 4, 0, 0);
    push(32'h8000_0000, 32'h7fff_ffff, 1, 32'hffff_ffff);
    push(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
    push_random(300);

    // Long receiver hold-off while the sender keeps offering
    wait (pending_q.size() < 250);
    hold_rx = 1'b1;
    repeat (300) @(posedge clk);
    hold_rx = 1'b0;

    // Threshold boundaries: S = 1 and S = 2 against 1, then the all-ones register
    set_threshold(32'h1);
    push(1, 0, 0, 0);
    push(1, 1, 0, 0);
    push(0, 0, 0, 32'hffff_ffff);
    push_random(100);
    set_threshold(32'hffff_ffff);
    push(32'h0001_0000, 0, 0, 0);
    push(32'h0000_ffff, 0, 0, 0);
    push(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    push(32'h0001_0000, 1, 0, 0);
    push_random(200);

    thr = '{32'h0, 32'h0000_0100, 32'h0001_0000, 32'h8000_0000, $urandom};
    for (int p = 0; p < 5; p++) begin
      set_threshold(thr[p]);
      rx_random = (p != 2);
      push_random(240);
    end
    rx_random = 1'b1;

    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("tb_quaternion_normalizer: clean");
    else
      $display("tb_quaternion_normalizer: errors");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/qn_pkg.sv
rtl/qn_front.sv
rtl/qn_lane.sv
rtl/quaternion_normalizer.sv
bench/tb_quaternion_normalizer.sv
